@@ hdl/bbn_pkg.sv @@
package bbn_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int CFG_BITS      = 11;
  localparam int CFG_IDX_BITS  = 1;
  localparam int COL_BITS      = 11;
  localparam int ROW_BITS      = 10;
  localparam int POS_BITS      = 22;
  localparam int HEIGHT_LIMIT  = 1024;
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int RESET_SIZE    = 64;
  localparam int FIFO_DEPTH    = 4;

  // arithmetic widths of the mean datapath
  localparam int CNT_BITS    = 4;
  localparam int COLSUM_BITS = SAMPLE_BITS + 2;
  localparam int SUM_BITS    = SAMPLE_BITS + 4;
  localparam int MAG_BITS    = SAMPLE_BITS + 3;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_BITS  = RECIP_SHIFT + 1;
  localparam int PROD_BITS   = MAG_BITS + RECIP_BITS;
  localparam int QC_BITS     = MAG_BITS + CNT_BITS;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'd1;

  typedef struct packed {
    logic                          kind;
    logic signed [SAMPLE_BITS-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mean_value;
    logic                          frame_last;
  } out_item_t;

  // which sides of the window fall outside the frame
  typedef struct packed {
    logic at_left;
    logic at_right;
    logic at_top;
    logic at_bottom;
  } border_t;

  // one classified item, front to back
  typedef struct packed {
    logic [COL_BITS-1:0]           x;
    logic signed [SAMPLE_BITS-1:0] val;
    logic                          emit;
    border_t                       border;
    logic                          last;
  } job_t;

  // floor(2^24 / cnt) for the counts a clipped 3x3 window can have
  function automatic logic [RECIP_BITS-1:0] recip_of(input logic [CNT_BITS-1:0] cnt);
    logic [RECIP_BITS-1:0] r;
    case (cnt)
      4'd2:    r = RECIP_BITS'(8388608);
      4'd3:    r = RECIP_BITS'(5592405);
      4'd4:    r = RECIP_BITS'(4194304);
      4'd6:    r = RECIP_BITS'(2796202);
      4'd9:    r = RECIP_BITS'(1864135);
      default: r = RECIP_BITS'(16777216);
    endcase
    return r;
  endfunction

endpackage

@@ hdl/bbn_ram.sv @@
module bbn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

@@ hdl/bbn_fifo.sv @@
module bbn_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bbn_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output bbn_pkg::job_t head
);
  import bbn_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);

  job_t          mem_r [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r, count_nxt;
  logic          do_wr, do_rd;

  assign full  = count_r == (PW+1)'(FIFO_DEPTH);
  assign empty = count_r == '0;
  assign head  = mem_r[rd_ptr_r];
  assign do_wr = push && !full;
  assign do_rd = pop && !empty;

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ hdl/bbn_front.sv @@
module bbn_front #(
  parameter int MAX_WIDTH = bbn_pkg::DEF_MAX_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bbn_pkg::in_item_t                 in_data,
  input  logic                              cfg_we,
  input  logic [bbn_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [bbn_pkg::CFG_BITS-1:0]      cfg_wdata,
  input  logic                              q_full,
  output logic                              q_push,
  output bbn_pkg::job_t                     q_job
);
  import bbn_pkg::*;

  logic [CFG_BITS-1:0] effw_r, effh_r, cfg_w, cfg_h;
  logic [POS_BITS-1:0] total_r, lastpos_r, total_nxt, lastpos_nxt;
  logic [POS_BITS-1:0] t_r, t_nxt;
  logic [COL_BITS-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [ROW_BITS-1:0] out_row_r, out_row_nxt;
  logic                cfg_hit, accept, in_frame, drop;

  function automatic logic [CFG_BITS-1:0] clamp_w(input logic [CFG_BITS-1:0] raw);
    logic [CFG_BITS-1:0] v;
    v = raw;
    if (raw == '0) begin
      v = CFG_BITS'(1);
    end else if (int'(raw) > MAX_WIDTH) begin
      v = CFG_BITS'(MAX_WIDTH);
    end
    return v;
  endfunction

  function automatic logic [CFG_BITS-1:0] clamp_h(input logic [CFG_BITS-1:0] raw);
    logic [CFG_BITS-1:0] v;
    v = raw;
    if (raw == '0) begin
      v = CFG_BITS'(1);
    end else if (int'(raw) > HEIGHT_LIMIT) begin
      v = CFG_BITS'(HEIGHT_LIMIT);
    end
    return v;
  endfunction

  // sizes are kept clamped; frame size and final position follow each write
  always_comb begin
    cfg_w   = effw_r;
    cfg_h   = effh_r;
    cfg_hit = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          cfg_w   = clamp_w(cfg_wdata);
          cfg_hit = 1'b1;
        end
        REG_FRAME_HEIGHT: begin
          cfg_h   = clamp_h(cfg_wdata);
          cfg_hit = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
    total_nxt   = POS_BITS'(cfg_w) * POS_BITS'(cfg_h);
    lastpos_nxt = total_nxt + POS_BITS'(cfg_w);
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign in_frame = t_r < total_r;
  // a flush before the frame is complete is swallowed
  assign drop     = (in_data.kind == KIND_FLUSH) && in_frame;
  assign q_push   = accept && !drop;

  always_comb begin
    q_job.x                = in_col_r;
    q_job.val              = in_frame ? in_data.sample_value : '0;
    q_job.emit             = t_r > POS_BITS'(effw_r);
    q_job.border.at_left   = out_col_r == '0;
    q_job.border.at_right  = (out_col_r + COL_BITS'(1)) >= effw_r;
    q_job.border.at_top    = out_row_r == '0;
    q_job.border.at_bottom = (CFG_BITS'(out_row_r) + CFG_BITS'(1)) >= effh_r;
    q_job.last             = q_job.emit && (t_r == lastpos_r);
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    t_nxt       = t_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_hit) begin
      in_col_nxt  = '0;
      t_nxt       = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (q_push) begin
      if ((in_col_r + COL_BITS'(1)) >= effw_r) begin
        in_col_nxt = '0;
      end else begin
        in_col_nxt = in_col_r + COL_BITS'(1);
      end
      t_nxt = t_r + POS_BITS'(1);
      if (q_job.emit) begin
        if ((out_col_r + COL_BITS'(1)) >= effw_r) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + ROW_BITS'(1);
        end else begin
          out_col_nxt = out_col_r + COL_BITS'(1);
        end
      end
      if (q_job.last) begin
        in_col_nxt  = '0;
        t_nxt       = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      effw_r    <= CFG_BITS'(RESET_SIZE);
      effh_r    <= CFG_BITS'(RESET_SIZE);
      total_r   <= POS_BITS'(RESET_SIZE * RESET_SIZE);
      lastpos_r <= POS_BITS'(RESET_SIZE * RESET_SIZE + RESET_SIZE);
      in_col_r  <= '0;
      t_r       <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      if (cfg_hit) begin
        effw_r    <= cfg_w;
        effh_r    <= cfg_h;
        total_r   <= total_nxt;
        lastpos_r <= lastpos_nxt;
      end
      in_col_r  <= in_col_nxt;
      t_r       <= t_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

endmodule

@@ hdl/bbn_back.sv @@
module bbn_back #(
  parameter int MAX_WIDTH = bbn_pkg::DEF_MAX_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  bbn_pkg::job_t      q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output bbn_pkg::out_item_t out_data
);
  import bbn_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int RW = 2 * SAMPLE_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;
  typedef logic signed [COLSUM_BITS-1:0] colsum_t;

  logic adv;

  // s1: job in flight, row store read pending
  logic          s1_valid_r;
  job_t          s1_job_r;
  logic          fwd_r;
  logic [RW-1:0] fwd_data_r;
  logic [RW-1:0] ram_rdata, ram_wdata, row_word;
  smp_t          up_eff, mid_eff;

  // s2: window holds the item's neighbourhood
  smp_t    window_r [9];
  logic    s2_valid_r, s2_last_r;
  border_t s2_border_r;

  // s3..s6: sum, magnitude, reciprocal product
  logic                s3_valid_r, s3_last_r;
  colsum_t             s3_colsum_r [3];
  logic [CNT_BITS-1:0] s3_cnt_r;
  colsum_t             colsum [3];
  logic [2:0]          row_on, col_on;
  logic [1:0]          nrow, ncol;
  logic [CNT_BITS-1:0] cnt_nxt;

  logic                       s4_valid_r, s4_last_r;
  logic signed [SUM_BITS-1:0] s4_sum_r;
  logic [CNT_BITS-1:0]        s4_cnt_r;

  logic                s5_valid_r, s5_last_r, s5_neg_r;
  logic [MAG_BITS-1:0] s5_n_r, mag_nxt;
  logic [SUM_BITS-1:0] abs_v;
  logic [CNT_BITS-1:0] s5_cnt_r;

  logic                 s6_valid_r, s6_last_r, s6_neg_r;
  logic [PROD_BITS-1:0] s6_prod_r;
  logic [MAG_BITS-1:0]  s6_n_r;
  logic [CNT_BITS-1:0]  s6_cnt_r;

  logic [MAG_BITS-1:0] q0, q_fix;
  logic [QC_BITS-1:0]  qc, rem_raw;
  smp_t                mean_nxt;

  logic      out_valid_r;
  out_item_t out_data_r;

  // whole pipeline moves together; output register is the last stage
  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && !q_empty;

  bbn_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_WIDTH)
  ) u_rows (
    .clk  (clk),
    .we   (adv && s1_valid_r),
    .waddr(AW'(s1_job_r.x)),
    .wdata(ram_wdata),
    .re   (q_pop),
    .raddr(AW'(q_head.x)),
    .rdata(ram_rdata)
  );

  // word = {row two above, row one above}; bypass for back-to-back same column
  assign row_word  = fwd_r ? fwd_data_r : ram_rdata;
  assign up_eff    = row_word[RW-1:SAMPLE_BITS];
  assign mid_eff   = row_word[SAMPLE_BITS-1:0];
  assign ram_wdata = {mid_eff, s1_job_r.val};

  always_comb begin
    row_on = {!s2_border_r.at_bottom, 1'b1, !s2_border_r.at_top};
    col_on = {!s2_border_r.at_right, 1'b1, !s2_border_r.at_left};
    for (int c = 0; c < 3; c++) begin
      colsum[c] = '0;
      for (int r = 0; r < 3; r++) begin
        if (row_on[r] && col_on[c]) begin
          colsum[c] = colsum[c] + COLSUM_BITS'(window_r[c*3+r]);
        end
      end
    end
    nrow    = 2'(row_on[0]) + 2'(row_on[1]) + 2'(row_on[2]);
    ncol    = 2'(col_on[0]) + 2'(col_on[1]) + 2'(col_on[2]);
    cnt_nxt = CNT_BITS'(nrow) * CNT_BITS'(ncol);
  end

  always_comb begin
    abs_v   = s4_sum_r[SUM_BITS-1] ? -s4_sum_r : s4_sum_r;
    mag_nxt = MAG_BITS'(abs_v) + MAG_BITS'(s4_cnt_r >> 1);
  end

  // quotient estimate is exact or one low; one compare fixes it
  always_comb begin
    q0       = s6_prod_r[RECIP_SHIFT +: MAG_BITS];
    qc       = QC_BITS'(q0) * QC_BITS'(s6_cnt_r);
    rem_raw  = QC_BITS'(s6_n_r) - qc;
    q_fix    = (rem_raw >= QC_BITS'(s6_cnt_r)) ? q0 + MAG_BITS'(1) : q0;
    mean_nxt = s6_neg_r ? SAMPLE_BITS'(-q_fix) : SAMPLE_BITS'(q_fix);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      s6_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        window_r[i] <= '0;
      end
    end else if (adv) begin
      s1_valid_r  <= q_pop;
      fwd_r       <= q_pop && s1_valid_r && (q_head.x == s1_job_r.x);
      s2_valid_r  <= s1_valid_r && s1_job_r.emit;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      s5_valid_r  <= s4_valid_r;
      s6_valid_r  <= s5_valid_r;
      out_valid_r <= s6_valid_r;
      if (s1_valid_r) begin
        for (int i = 0; i < 6; i++) begin
          window_r[i] <= window_r[i+3];
        end
        window_r[6] <= up_eff;
        window_r[7] <= mid_eff;
        window_r[8] <= s1_job_r.val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_job_r    <= q_head;
      fwd_data_r  <= ram_wdata;
      s2_border_r <= s1_job_r.border;
      s2_last_r   <= s1_job_r.last;
      s3_colsum_r <= colsum;
      s3_cnt_r    <= cnt_nxt;
      s3_last_r   <= s2_last_r;
      s4_sum_r    <= SUM_BITS'(s3_colsum_r[0]) + SUM_BITS'(s3_colsum_r[1])
                     + SUM_BITS'(s3_colsum_r[2]);
      s4_cnt_r    <= s3_cnt_r;
      s4_last_r   <= s3_last_r;
      s5_neg_r    <= s4_sum_r[SUM_BITS-1];
      s5_n_r      <= mag_nxt;
      s5_cnt_r    <= s4_cnt_r;
      s5_last_r   <= s4_last_r;
      s6_prod_r   <= PROD_BITS'(s5_n_r) * PROD_BITS'(recip_of(s5_cnt_r));
      s6_n_r      <= s5_n_r;
      s6_neg_r    <= s5_neg_r;
      s6_cnt_r    <= s5_cnt_r;
      s6_last_r   <= s5_last_r;
      out_data_r.mean_value <= mean_nxt;
      out_data_r.frame_last <= s6_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cnt_legal: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> (s3_cnt_r == CNT_BITS'(1) || s3_cnt_r == CNT_BITS'(2) ||
                    s3_cnt_r == CNT_BITS'(3) || s3_cnt_r == CNT_BITS'(4) ||
                    s3_cnt_r == CNT_BITS'(6) || s3_cnt_r == CNT_BITS'(9)))
    else $error("window count not a clipped 3x3 size");

  a_recip_err: assert property (@(posedge clk) disable iff (!rst_n)
    s6_valid_r |-> (rem_raw < (QC_BITS'(s6_cnt_r) << 1)))
    else $error("reciprocal estimate off by more than one");

  a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
    s6_valid_r |-> (q_fix <= (MAG_BITS'(1) << (SAMPLE_BITS - 1))))
    else $error("mean magnitude exceeds sample range");

  a_fwd_live: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_valid_r)
    else $error("row bypass armed with no job in flight");

endmodule

@@ hdl/box_blur_3x3_edge_normalized.sv @@
// Clipped 3x3 box mean over a raster-ordered Q3.12 field.
//
// in_*  : valid/ready. Each transfer is a field sample (kind = sample) or a
//         flush tick (kind = flush). After the last sample of a frame, send
//         frame_width+1 flush ticks to drain it; an early flush is dropped.
// out_* : valid/ready. One mean per frame sample in raster order, rounded to
//         nearest (ties away from zero); frame_last marks the final one.
// cfg_* : write-only. Index 0 frame_width, 1 frame_height. A write restarts
//         the frame; do it only with the block idle.
//
// Throughput: one transfer per clock in each direction, sustained while out_ready stays high.
// Latency: the result for a sample is ready once frame_width+1 further items
// are in; it then reaches out_* through the queue, row store read, window,
// three adder stages, reciprocal multiply and the output register.
// Reset: sizes 64x64, position counters and window cleared. The row stores
// need no clearing: unwritten columns only feed rows outside the frame.
// A stalled receiver freezes the back pipeline; the 4-entry queue then
// fills and in_ready drops.
module box_blur_3x3_edge_normalized #(
  parameter int MAX_WIDTH = bbn_pkg::DEF_MAX_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bbn_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bbn_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [bbn_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [bbn_pkg::CFG_BITS-1:0]     cfg_wdata
);
  import bbn_pkg::*;

  // front -> queue
  logic q_push, q_full;
  job_t q_job;

  // queue -> back
  logic q_pop, q_empty;
  job_t q_head;

  // Front: frame position, clamped sizes, drops early flushes, tags each job
  // with its border flags and whether it releases a result.
  bbn_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  // Short queue so input transfers continue while the back end is stalled.
  bbn_fifo u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_job(q_job),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .head    (q_head)
  );

  // Back: row stores, 3x3 window, masked sum and divide by the window count.
  bbn_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the clipped 3x3 box mean.
// Stimulus goes through a queue: the initial block fills it frame by frame,
// and a clocked driver feeds the in_ channel from it with random gaps. Every
// accepted transfer steps a local copy of the window pipeline, which adds
// the expected mean (if any) to expected_means. The monitor pops that
// queue on every accepted out_ transfer and compares field by field.
module tb;
  import bbn_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 11;
  // covers the block pipeline plus a 4-deep input queue; leave plenty
  localparam int DRAIN_WAIT   = 32;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int ITEM_TARGET  = 1050;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_BITS-1:0]     cfg_wdata = '0;

  box_blur_3x3_edge_normalized uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------
  // Local copy of the blur datapath
  // ---------------------------------------------------------------------
  logic [CFG_BITS-1:0]           width_reg;
  logic [CFG_BITS-1:0]           height_reg;
  logic signed [SAMPLE_BITS-1:0] upper_row  [DEF_MAX_WIDTH];
  logic signed [SAMPLE_BITS-1:0] middle_row [DEF_MAX_WIDTH];
  // column-major: index = column*3 + row, column 0 = left, row 0 = top
  logic signed [SAMPLE_BITS-1:0] win [9];
  int unsigned col_in, row_in, col_out, row_out;

  out_item_t expected_means [$];
  in_item_t  pending_items  [$];

  int  error_count  = 0;
  int  cycle_count  = 0;
  int  items_queued = 0;
  bit  steady       = 1'b0;   // when set, neither side idles
  int unsigned send_gap  = 0;
  int unsigned hold_left = 0;

  // a size of 0 behaves as 1, anything past the limit as the limit
  function automatic int unsigned clip_size(input logic [CFG_BITS-1:0] raw,
                                            input int unsigned limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  function automatic void restart_positions();
    col_in  = 0;
    row_in  = 0;
    col_out = 0;
    row_out = 0;
  endfunction

  function automatic void clear_blur_model();
    width_reg  = CFG_BITS'(RESET_SIZE);
    height_reg = CFG_BITS'(RESET_SIZE);
    foreach (upper_row[i]) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    restart_positions();
  endfunction

  // any register write drops the frame in progress
  function automatic void apply_size_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                         input logic [CFG_BITS-1:0] value);
    if (idx == REG_FRAME_WIDTH) width_reg = value;
    else if (idx == REG_FRAME_HEIGHT) height_reg = value;
    restart_positions();
  endfunction

  // one accepted transfer through the line buffers and window
  task automatic blur_window_step(input in_item_t item);
    int unsigned w, h, total, t, x, cnt;
    int sum, mag, q;
    logic signed [SAMPLE_BITS-1:0] val, up, mid;
    out_item_t res;
    w     = clip_size(width_reg, DEF_MAX_WIDTH);
    h     = clip_size(height_reg, HEIGHT_LIMIT);
    total = w * h;
    t     = row_in * w + col_in;
    x     = col_in % DEF_MAX_WIDTH;
    // early flush: dropped without a trace
    if (item.kind == KIND_FLUSH && t < total) return;
    // past the frame end, a sample is just another flush tick
    val = (t < total) ? item.sample_value : '0;
    up  = upper_row[x];
    mid = middle_row[x];
    upper_row[x]  = mid;
    middle_row[x] = val;
    for (int c = 0; c < 6; c++) win[c] = win[c + 3];
    win[6] = up;
    win[7] = mid;
    win[8] = val;
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
    end
    if (t < w + 1) return;
    sum = 0;
    cnt = 0;
    for (int c = 0; c < 3; c++) begin
      if ((c == 0 && col_out == 0) || (c == 2 && col_out + 1 >= w)) continue;
      for (int r = 0; r < 3; r++) begin
        if ((r == 0 && row_out == 0) || (r == 2 && row_out + 1 >= h)) continue;
        sum += win[c * 3 + r];
        cnt++;
      end
    end
    // round to nearest, ties away from zero
    mag = (sum < 0) ? -sum : sum;
    q   = (mag + int'(cnt / 2)) / int'(cnt);
    if (sum < 0) q = -q;
    res.mean_value = q[SAMPLE_BITS-1:0];
    res.frame_last = (row_out * w + col_out + 1 >= total);
    expected_means.insert(expected_means.size(), res);
    col_out++;
    if (col_out >= w) begin
      col_out = 0;
      row_out++;
    end
    if (res.frame_last) restart_positions();
  endtask

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if (steady) return 0;
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5, 6, 7: return 0;
      15:                     return $urandom_range(8, 24);
      default:                return $urandom_range(1, 3);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Driver: one transfer per free slot, gap chosen after each one
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) blur_window_step(in_data);
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_items.size() != 0) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random back-pressure, compare against the oldest expectation
  // ---------------------------------------------------------------------
  function automatic void report_mismatch(input string what, input out_item_t want,
                                          input out_item_t got);
    if (error_count < 10)
      $display("%0t: %s: expected mean %0d last %0b, got mean %0d last %0b",
               $time, what, want.mean_value, want.frame_last,
               got.mean_value, got.frame_last);
    error_count++;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_means.size() == 0) begin
          report_mismatch("mean with nothing outstanding", '0, out_data);
        end else begin
          want = expected_means.pop_front();
          if (out_data.mean_value !== want.mean_value ||
              out_data.frame_last !== want.frame_last)
            report_mismatch("mean mismatch", want, out_data);
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold_left <= pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[box_blur_3x3_edge_normalized] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic in_item_t make_item(input logic kind,
                                         input logic [SAMPLE_BITS-1:0] value);
    in_item_t item;
    item.kind         = kind;
    item.sample_value = value;
    return item;
  endfunction

  // every item for the driver goes through here so the run length is known
  function automatic void queue_item(input in_item_t item);
    pending_items.insert(pending_items.size(), item);
    items_queued++;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_value(input int style);
    case (style)
      1: begin
        case ($urandom_range(0, 3))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'h8001;
          default: return 16'h0000;
        endcase
      end
      // tiny values make the rounding ties frequent
      2:       return SAMPLE_BITS'(int'($urandom_range(0, 6)) - 3);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // wait for the sender to empty and every mean to arrive, then let the
  // pipeline settle (dropped flushes leave nothing to wait on)
  task automatic settle();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_means.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_BITS-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_size_reg(idx, value);
  endtask

  // only touches the registers when needed, so unchanged frames stream
  task automatic resize(input logic [CFG_BITS-1:0] w_raw,
                        input logic [CFG_BITS-1:0] h_raw, input bit rewrite);
    if (rewrite || w_raw != width_reg || h_raw != height_reg) begin
      settle();
      if (rewrite || w_raw != width_reg) write_reg(REG_FRAME_WIDTH, w_raw);
      if (h_raw != height_reg) write_reg(REG_FRAME_HEIGHT, h_raw);
    end
  endtask

  // w+1 ticks drain a frame; noisy ones swap some for late samples
  task automatic queue_drain(input int unsigned w, input bit noisy);
    for (int unsigned i = 0; i <= w; i++) begin
      if (noisy && $urandom_range(0, 3) == 0)
        queue_item(make_item(KIND_SAMPLE, SAMPLE_BITS'($urandom)));
      else
        queue_item(make_item(KIND_FLUSH, noisy ? SAMPLE_BITS'($urandom) : '0));
    end
  endtask

  // keep < w*h leaves the frame unfinished; the next register write drops it
  task automatic queue_frame(input int unsigned w, input int unsigned h,
                             input int unsigned keep, input int style, input bit noisy);
    int unsigned pause_at;
    pause_at = keep;
    if (noisy && $urandom_range(0, 7) == 0) pause_at = $urandom_range(0, keep - 1);
    for (int unsigned i = 0; i < keep; i++) begin
      if (i == pause_at) settle();
      if (noisy && $urandom_range(0, 11) == 0)
        queue_item(make_item(KIND_FLUSH, SAMPLE_BITS'($urandom)));
      queue_item(make_item(KIND_SAMPLE, pick_value(style)));
    end
    if (keep == w * h) queue_drain(w, noisy);
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    int unsigned frame_no, w, h, keep;
    logic [CFG_BITS-1:0] w_raw, h_raw;
    bit big, rewrite_due;

    clear_blur_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // three rows at the reset size, before any register write; the first
    // write below drops the rest of the frame
    queue_frame(RESET_SIZE, RESET_SIZE, 3 * RESET_SIZE, 0, 1'b1);

    // zero sizes behave as 1x1; the leading flush is early and dropped
    resize(0, 0, 1'b0);
    queue_item(make_item(KIND_FLUSH, '0));
    queue_item(make_item(KIND_SAMPLE, 16'h7FFF));
    queue_drain(1, 1'b0);

    // 3x1: ties at both ends (+0.5 up, -0.5 down), divide by 3 in the middle,
    // and a late sample in the drain
    resize(3, 1, 1'b0);
    queue_item(make_item(KIND_SAMPLE, 16'h0001));
    queue_item(make_item(KIND_SAMPLE, 16'h0000));
    queue_item(make_item(KIND_SAMPLE, 16'hFFFF));
    queue_item(make_item(KIND_FLUSH, '0));
    queue_item(make_item(KIND_SAMPLE, 16'h1234));
    queue_item(make_item(KIND_FLUSH, '0));
    queue_item(make_item(KIND_FLUSH, '0));

    // 3x3 at the negative extreme: divisors 4, 6 and 9
    resize(3, 3, 1'b0);
    repeat (9) queue_item(make_item(KIND_SAMPLE, 16'h8000));
    queue_drain(3, 1'b0);

    // unfinished frame, dropped by the register write that follows
    resize(4, 2, 1'b0);
    repeat (6) queue_item(make_item(KIND_SAMPLE, SAMPLE_BITS'($urandom)));
    rewrite_due = 1'b1;

    // random frames, mostly small; a few short ones at or past the size limits
    frame_no = 0;
    while (items_queued < ITEM_TARGET) begin
      frame_no++;
      steady = ($urandom_range(0, 7) == 0);
      big    = 1'b0;
      case (frame_no % 24)
        6: begin
          w_raw = CFG_BITS'($urandom_range(1024, 2047));
          h_raw = CFG_BITS'($urandom_range(1, 2));
          big   = 1'b1;
        end
        18: begin
          w_raw = CFG_BITS'($urandom_range(1, 2));
          h_raw = CFG_BITS'($urandom_range(1025, 2047));
          big   = 1'b1;
        end
        default: begin
          w_raw = CFG_BITS'($urandom_range(0, 9));
          h_raw = CFG_BITS'($urandom_range(0, 7));
        end
      endcase
      resize(w_raw, h_raw, rewrite_due || $urandom_range(0, 9) == 0);
      w    = clip_size(w_raw, DEF_MAX_WIDTH);
      h    = clip_size(h_raw, HEIGHT_LIMIT);
      keep = w * h;
      rewrite_due = 1'b0;
      if (big) begin
        // clamped sizes, cut short so the run stays small
        keep        = $urandom_range(1, 40);
        rewrite_due = 1'b1;
      end else if (keep > 1 && $urandom_range(0, 9) == 0) begin
        keep        = $urandom_range(1, keep - 1);
        rewrite_due = 1'b1;
      end
      queue_frame(w, h, keep, big ? 0 : int'($urandom_range(0, 3)), !big);
    end

    settle();
    if (error_count == 0) begin
      $display("[box_blur_3x3_edge_normalized] OK");
    end else begin
      $display("[box_blur_3x3_edge_normalized] ERROR");
    end
    $finish;
  end

endmodule
